>>> src/cubic_bezier_evaluator_assert.svh
// assertion macros used by the checker file
`ifndef CUBIC_BEZIER_EVALUATOR_ASSERT_SVH
`define CUBIC_BEZIER_EVALUATOR_ASSERT_SVH

// checked only while reset is released
`define CBE_ASSERT_RUN(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("cubic bezier evaluator check failed");

// checked at every edge, reset included
`define CBE_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("cubic bezier evaluator check failed");

`endif

>>> src/cbe_pkg.sv
// shared types and constants for the cubic bezier evaluator
package cbe_pkg;

    // integer bits that results gain over the coordinates
    localparam int OUT_GUARD_BITS = 8;

    // advance strobes for the pipeline stages inside the basis unit
    typedef struct packed {
        logic s2;
        logic s3;
    } t_adv;

endpackage

>>> src/cbe_basis.sv
// bernstein weights and derivative weights from the curve parameter, two stages
module cbe_basis
    import cbe_pkg::*;
#(
    parameter int T_FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  t_adv                          i_adv,
    input  logic [T_FRAC_BITS:0]          i_t,
    output logic signed [T_FRAC_BITS+5:0] o_wp [4],
    output logic signed [T_FRAC_BITS+5:0] o_wd [4]
);

    localparam int F  = T_FRAC_BITS;
    localparam int TW = F + 1;
    localparam int DW = F + 6;
    localparam int ZX = DW - TW;
    localparam logic [TW-1:0] ONE = {1'b1, {F{1'b0}}};

    // stage 2: squares
    logic [TW-1:0]   u;
    logic [2*TW-1:0] tt;
    logic [2*TW-1:0] uu;
    logic [TW-1:0]   r_t;
    logic [TW-1:0]   r_u;
    logic [TW-1:0]   r_t2;
    logic [TW-1:0]   r_u2;

    assign u  = ONE - i_t;
    assign tt = i_t * i_t;
    assign uu = u * u;

    always_ff @(posedge i_clk) begin
        if (i_adv.s2) begin
            r_t  <= i_t;
            r_u  <= u;
            r_t2 <= tt[2*F:F];
            r_u2 <= uu[2*F:F];
        end
    end

    // stage 3: cubes and the weight combinations
    logic [2*TW-1:0]       m0, m1, m2, m3;
    logic signed [DW-1:0]  w0, w1, w2, w3;
    logic signed [DW-1:0]  td, t2d, u2d, one_d, t2x3, g1, g2;
    logic signed [DW-1:0]  wp [4];
    logic signed [DW-1:0]  wd [4];
    logic signed [DW-1:0]  r_wp [4];
    logic signed [DW-1:0]  r_wd [4];

    assign m0 = r_u2 * r_u;
    assign m1 = r_t * r_u2;
    assign m2 = r_t2 * r_u;
    assign m3 = r_t2 * r_t;

    always_comb begin
        w0    = $signed({{ZX{1'b0}}, m0[2*F:F]});
        w1    = $signed({{ZX{1'b0}}, m1[2*F:F]});
        w2    = $signed({{ZX{1'b0}}, m2[2*F:F]});
        w3    = $signed({{ZX{1'b0}}, m3[2*F:F]});
        td    = $signed({{ZX{1'b0}}, r_t});
        t2d   = $signed({{ZX{1'b0}}, r_t2});
        u2d   = $signed({{ZX{1'b0}}, r_u2});
        one_d = $signed({{ZX{1'b0}}, ONE});
        t2x3  = (t2d <<< 1) + t2d;
        g1    = one_d - (td <<< 2) + t2x3;
        g2    = (td <<< 1) - t2x3;
        wp[0] = w0;
        wp[1] = (w1 <<< 1) + w1;
        wp[2] = (w2 <<< 1) + w2;
        wp[3] = w3;
        // derivative weights carry the factor three already
        wd[0] = -((u2d <<< 1) + u2d);
        wd[1] = (g1 <<< 1) + g1;
        wd[2] = (g2 <<< 1) + g2;
        wd[3] = t2x3;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s3) begin
            for (int k = 0; k < 4; k++) begin
                r_wp[k] <= wp[k];
                r_wd[k] <= wd[k];
            end
        end
    end

    assign o_wp = r_wp;
    assign o_wd = r_wd;

endmodule

>>> src/cubic_bezier_evaluator.sv
// cubic bezier point, first and second derivative evaluator, top level
//
// Each request carries four 2-D control points and a parameter t; one result
// with the curve point, first and second derivative (x and y) comes back. The
// datapath is a six-stage pipeline (clamp and difference sums, squares, cubes,
// coordinate-by-weight multiplies, pairwise sums, final sum) and takes one
// request per clock while results are taken. Every stage has its own valid bit
// and advances when it is empty or its successor advances, so an output stall
// only holds the stages that are full and empty slots ahead still fill up. t
// above one is treated as one; products truncate toward minus infinity.
module cubic_bezier_evaluator
    import cbe_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int T_FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // ctrl0_x, ctrl0_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, ctrl3_x, ctrl3_y, param_t
    input  logic [((8*COORD_WIDTH+T_FRAC_BITS+1+7)/8)*8-1:0] i_s_axis_tdata,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // pos_x, pos_y, slope_x, slope_y, bend_x, bend_y
    output logic [((6*(COORD_WIDTH+OUT_GUARD_BITS)+7)/8)*8-1:0] o_m_axis_tdata
);

    localparam int CW    = COORD_WIDTH;
    localparam int F     = T_FRAC_BITS;
    localparam int TW    = F + 1;
    localparam int OW    = CW + OUT_GUARD_BITS;
    localparam int DW    = F + 6;
    localparam int AW    = OW + F;
    localparam int EW    = CW + 4;
    localparam int ATW   = EW + TW + 1;
    localparam int PW    = CW + DW;
    localparam int OUT_W = ((6*OW+7)/8)*8;
    localparam int NST   = 6;
    localparam logic [TW-1:0] ONE = {1'b1, {F{1'b0}}};

    // stage handshake
    logic [NST-1:0] r_v;
    logic [NST-1:0] n_v;
    logic [NST-1:0] adv;
    t_adv           basis_adv;

    always_comb begin
        adv[NST-1] = !r_v[NST-1] || i_m_axis_tready;
        for (int k = NST-2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
        n_v = r_v;
        if (adv[0]) begin
            n_v[0] = i_s_axis_tvalid;
        end
        for (int k = 1; k < NST; k++) begin
            if (adv[k]) begin
                n_v[k] = r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_s_axis_tready = adv[0];
    assign o_m_axis_tvalid = r_v[NST-1];
    assign basis_adv.s2    = adv[1];
    assign basis_adv.s3    = adv[2];

    // stage 1: unpack, clamp t, control point difference sums
    logic signed [CW-1:0] in_c [8];
    logic [TW-1:0]        t_in;
    logic [TW-1:0]        t_cl;
    logic signed [EW-1:0] e [8];
    logic signed [EW-1:0] a_sum [2];
    logic signed [EW-1:0] b_sum [2];
    logic signed [CW-1:0] r1_c [8];
    logic signed [EW-1:0] r1_a [2];
    logic signed [EW-1:0] r1_b [2];
    logic [TW-1:0]        r1_t;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            in_c[i] = $signed(i_s_axis_tdata[i*CW +: CW]);
            e[i]    = {{(EW-CW){in_c[i][CW-1]}}, in_c[i]};
        end
        t_in = i_s_axis_tdata[8*CW +: TW];
        t_cl = (t_in[F] && (|t_in[F-1:0])) ? ONE : t_in;
        for (int ax = 0; ax < 2; ax++) begin
            a_sum[ax] = -e[ax] + (e[2+ax] <<< 1) + e[2+ax]
                        - (e[4+ax] <<< 1) - e[4+ax] + e[6+ax];
            b_sum[ax] = e[ax] - (e[2+ax] <<< 1) + e[4+ax];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r1_c <= in_c;
            r1_a <= a_sum;
            r1_b <= b_sum;
            r1_t <= t_cl;
        end
    end

    // stages 2 and 3 of the weights
    logic signed [DW-1:0] wp [4];
    logic signed [DW-1:0] wd [4];

    cbe_basis #(
        .T_FRAC_BITS(T_FRAC_BITS)
    ) u_basis (
        .i_clk (i_clk),
        .i_adv (basis_adv),
        .i_t   (r1_t),
        .o_wp  (wp),
        .o_wd  (wd)
    );

    // stage 2: second derivative slope term
    logic signed [ATW-1:0] r2_at [2];
    logic signed [EW-1:0]  r2_b [2];
    logic signed [CW-1:0]  r2_c [8];

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            for (int ax = 0; ax < 2; ax++) begin
                r2_at[ax] <= r1_a[ax] * $signed({1'b0, r1_t});
            end
            r2_b <= r1_b;
            r2_c <= r1_c;
        end
    end

    // stage 3: second derivative before the factor six
    logic signed [AW-1:0] r3_inner [2];
    logic signed [CW-1:0] r3_c [8];

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            for (int ax = 0; ax < 2; ax++) begin
                r3_inner[ax] <= {{(AW-ATW){r2_at[ax][ATW-1]}}, r2_at[ax]}
                                + ({{(AW-EW){r2_b[ax][EW-1]}}, r2_b[ax]} <<< F);
            end
            r3_c <= r2_c;
        end
    end

    // stage 4: coordinate by weight products
    logic signed [PW-1:0] pp [2][4];
    logic signed [PW-1:0] pq [2][4];
    logic signed [AW-1:0] r4_p [2][4];
    logic signed [AW-1:0] r4_q [2][4];
    logic signed [AW-1:0] r4_bend [2];

    always_comb begin
        for (int ax = 0; ax < 2; ax++) begin
            for (int k = 0; k < 4; k++) begin
                pp[ax][k] = r3_c[2*k+ax] * wp[k];
                pq[ax][k] = r3_c[2*k+ax] * wd[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            for (int ax = 0; ax < 2; ax++) begin
                for (int k = 0; k < 4; k++) begin
                    r4_p[ax][k] <= {{(AW-PW){pp[ax][k][PW-1]}}, pp[ax][k]};
                    r4_q[ax][k] <= {{(AW-PW){pq[ax][k][PW-1]}}, pq[ax][k]};
                end
                r4_bend[ax] <= (r3_inner[ax] <<< 2) + (r3_inner[ax] <<< 1);
            end
        end
    end

    // stage 5: pairwise sums
    logic signed [AW-1:0] r5_pa [2];
    logic signed [AW-1:0] r5_pb [2];
    logic signed [AW-1:0] r5_sa [2];
    logic signed [AW-1:0] r5_sb [2];
    logic signed [AW-1:0] r5_bend [2];

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            for (int ax = 0; ax < 2; ax++) begin
                r5_pa[ax]   <= r4_p[ax][0] + r4_p[ax][1];
                r5_pb[ax]   <= r4_p[ax][2] + r4_p[ax][3];
                r5_sa[ax]   <= r4_q[ax][0] + r4_q[ax][1];
                r5_sb[ax]   <= r4_q[ax][2] + r4_q[ax][3];
                r5_bend[ax] <= r4_bend[ax];
            end
        end
    end

    // stage 6: output register, drop the fraction of the products
    logic signed [AW-1:0] pos_sum [2];
    logic signed [AW-1:0] slope_sum [2];
    logic [OW-1:0]        r6_pos [2];
    logic [OW-1:0]        r6_slope [2];
    logic [OW-1:0]        r6_bend [2];

    always_comb begin
        for (int ax = 0; ax < 2; ax++) begin
            pos_sum[ax]   = r5_pa[ax] + r5_pb[ax];
            slope_sum[ax] = r5_sa[ax] + r5_sb[ax];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            for (int ax = 0; ax < 2; ax++) begin
                r6_pos[ax]   <= pos_sum[ax][AW-1:F];
                r6_slope[ax] <= slope_sum[ax][AW-1:F];
                r6_bend[ax]  <= r5_bend[ax][AW-1:F];
            end
        end
    end

    always_comb begin
        o_m_axis_tdata = '0;
        o_m_axis_tdata[0*OW +: OW] = r6_pos[0];
        o_m_axis_tdata[1*OW +: OW] = r6_pos[1];
        o_m_axis_tdata[2*OW +: OW] = r6_slope[0];
        o_m_axis_tdata[3*OW +: OW] = r6_slope[1];
        o_m_axis_tdata[4*OW +: OW] = r6_bend[0];
        o_m_axis_tdata[5*OW +: OW] = r6_bend[1];
    end

endmodule

>>> src/cbe_checker.sv
// port-level checks for the cubic bezier evaluator and their binding
`include "cubic_bezier_evaluator_assert.svh"

module cbe_checker #(
    parameter int OUT_W = 240
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_s_axis_tready,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata
);

    // a result that is not taken stays put
    `CBE_ASSERT_RUN(a_out_hold,
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // an empty output register means no stage can be blocked
    `CBE_ASSERT_RUN(a_ready_when_out_empty, !o_m_axis_tvalid |-> o_s_axis_tready)

    // a full stalled pipeline stays full until the output moves
    `CBE_ASSERT_RUN(a_full_stays_full,
        !o_s_axis_tready && !i_m_axis_tready |=> !o_s_axis_tready || i_m_axis_tready)

    // reset empties the pipeline
    `CBE_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_m_axis_tvalid)

endmodule

bind cubic_bezier_evaluator cbe_checker #(
    .OUT_W(OUT_W)
) u_cbe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
